@@ hw/rtl/modbus_tcp_response_parser_defines.svh @@
// assertion macros for the modbus tcp response parser
// used by files that check their own logic; no other dependencies
`ifndef MODBUS_TCP_RESPONSE_PARSER_DEFINES_SVH
`define MODBUS_TCP_RESPONSE_PARSER_DEFINES_SVH

// checked only outside reset
`define MBTCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define MBTCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/mbtcp_pkg.sv @@
// shared types and constants of the modbus tcp response parser
// no dependencies
`timescale 1ns / 1ps

package mbtcp_pkg;

  localparam int unsigned PosW      = 9;
  localparam int unsigned FifoDepth = 4;

  localparam logic [PosW-1:0] HeaderBytes = 9'd9;
  localparam logic [PosW-1:0] PosMax      = 9'd511;

  // function codes
  localparam logic [7:0] FcReadCoils    = 8'h01;
  localparam logic [7:0] FcReadDiscrete = 8'h02;
  localparam logic [7:0] FcReadHolding  = 8'h03;
  localparam logic [7:0] FcReadInput    = 8'h04;
  localparam logic [7:0] FcWriteCoil    = 8'h05;
  localparam logic [7:0] FcWriteReg     = 8'h06;
  localparam logic [7:0] FcWriteCoils   = 8'h0F;
  localparam logic [7:0] FcWriteRegs    = 8'h10;

  // result kinds
  localparam logic [1:0] KindWord   = 2'd0;
  localparam logic [1:0] KindCoil   = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  // frame status codes
  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatDataErr   = 2'd1;
  localparam logic [1:0] StatProtoErr  = 2'd2;
  localparam logic [1:0] StatException = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] item_value;
    logic [1:0]  frame_status;
    logic [7:0]  exception_code;
    logic        is_last;
  } res_t;

  // which result slots the parser fills for one byte
  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

endpackage

@@ hw/rtl/mbtcp_parser.sv @@
// per-byte frame state and result formation for the modbus tcp parser
// depends on mbtcp_pkg
`timescale 1ns / 1ps

module mbtcp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  mbtcp_pkg::in_t       in_data_i,
  input  logic [15:0]          exp_tid_i,
  output mbtcp_pkg::res_t      res0_o,
  output mbtcp_pkg::res_t      res1_o,
  output mbtcp_pkg::push_t     push_o
);

  localparam int unsigned PosW = mbtcp_pkg::PosW;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     tid_q, tid_d;
  logic            bad_q, bad_d;
  logic [7:0]      fc_q, fc_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [7:0]      hold_q, hold_d;

  logic            data_v;
  mbtcp_pkg::res_t data_res;
  mbtcp_pkg::res_t stat_res;
  logic [PosW-1:0] idx;
  logic [PosW:0]   len;
  logic [7:0]      b;
  logic            fend;

  assign b    = in_data_i.data_byte;
  assign fend = in_data_i.frame_end;
  assign idx  = pos_q - mbtcp_pkg::HeaderBytes;
  assign len  = {1'b0, pos_q} + (PosW+1)'(1);

  always_comb begin
    pos_d    = pos_q;
    tid_d    = tid_q;
    bad_d    = bad_q;
    fc_d     = fc_q;
    cnt_d    = cnt_q;
    hold_d   = hold_q;
    data_v   = 1'b0;
    data_res = '0;
    stat_res = '0;
    stat_res.item_kind = mbtcp_pkg::KindStatus;
    stat_res.is_last   = 1'b1;

    if (accept_i) begin
      if (pos_q == PosW'(0)) begin
        tid_d = {b, 8'h00};
      end else if (pos_q == PosW'(1)) begin
        tid_d = {tid_q[15:8], b};
        if ({tid_q[15:8], b} != exp_tid_i) begin
          bad_d = 1'b1;
        end
      end else if (pos_q == PosW'(2) || pos_q == PosW'(3)) begin
        if (b != 8'h00) begin
          bad_d = 1'b1;
        end
      end else if (pos_q == PosW'(7)) begin
        fc_d = b;
      end else if (pos_q == PosW'(8)) begin
        cnt_d = b;
      end else if (pos_q >= mbtcp_pkg::HeaderBytes && !bad_q) begin
        if (idx < {{(PosW-8){1'b0}}, cnt_q}) begin
          if (fc_q == mbtcp_pkg::FcReadHolding || fc_q == mbtcp_pkg::FcReadInput) begin
            // even offset is the high byte, odd offset closes the word
            if (!idx[0]) begin
              hold_d = b;
            end else begin
              data_v = 1'b1;
              data_res.item_kind  = mbtcp_pkg::KindWord;
              data_res.item_value = {hold_q, b};
            end
          end else if (fc_q == mbtcp_pkg::FcReadCoils ||
                       fc_q == mbtcp_pkg::FcReadDiscrete) begin
            data_v = 1'b1;
            data_res.item_kind  = mbtcp_pkg::KindCoil;
            data_res.item_value = {8'h00, b};
          end
        end
      end

      if (pos_q != mbtcp_pkg::PosMax) begin
        pos_d = pos_q + PosW'(1);
      end

      if (fend) begin
        // status uses the header state as updated by this byte
        if (len < {1'b0, mbtcp_pkg::HeaderBytes}) begin
          stat_res.frame_status = mbtcp_pkg::StatDataErr;
        end else if (bad_d) begin
          stat_res.frame_status = mbtcp_pkg::StatProtoErr;
        end else if (fc_d[7]) begin
          stat_res.frame_status   = mbtcp_pkg::StatException;
          stat_res.exception_code = cnt_d;
        end else if (fc_d >= mbtcp_pkg::FcReadCoils && fc_d <= mbtcp_pkg::FcReadInput) begin
          if (len < ({1'b0, mbtcp_pkg::HeaderBytes} + {{(PosW-7){1'b0}}, cnt_d})) begin
            stat_res.frame_status = mbtcp_pkg::StatDataErr;
          end else begin
            stat_res.frame_status = mbtcp_pkg::StatOk;
          end
        end else if (fc_d == mbtcp_pkg::FcWriteCoil || fc_d == mbtcp_pkg::FcWriteReg ||
                     fc_d == mbtcp_pkg::FcWriteCoils || fc_d == mbtcp_pkg::FcWriteRegs) begin
          stat_res.frame_status = mbtcp_pkg::StatOk;
        end else begin
          stat_res.frame_status = mbtcp_pkg::StatProtoErr;
        end
        pos_d  = '0;
        tid_d  = '0;
        bad_d  = 1'b0;
        fc_d   = '0;
        cnt_d  = '0;
        hold_d = '0;
      end
    end
  end

  // data result goes first, the status follows in the second slot
  assign res0_o    = data_v ? data_res : stat_res;
  assign res1_o    = stat_res;
  assign push_o.v0 = accept_i && (data_v || fend);
  assign push_o.v1 = accept_i && data_v && fend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      tid_q  <= '0;
      bad_q  <= 1'b0;
      fc_q   <= '0;
      cnt_q  <= '0;
      hold_q <= '0;
    end else begin
      pos_q  <= pos_d;
      tid_q  <= tid_d;
      bad_q  <= bad_d;
      fc_q   <= fc_d;
      cnt_q  <= cnt_d;
      hold_q <= hold_d;
    end
  end

endmodule

@@ hw/rtl/mbtcp_result_fifo.sv @@
// result queue of the modbus tcp parser, takes up to two results per cycle
// depends on mbtcp_pkg; depth must be a power of two, at least 4
`timescale 1ns / 1ps

module mbtcp_result_fifo #(
  parameter int unsigned Depth = mbtcp_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbtcp_pkg::push_t  push_i,
  input  mbtcp_pkg::res_t   res0_i,
  input  mbtcp_pkg::res_t   res1_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mbtcp_pkg::res_t   out_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

  mbtcp_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_nxt;
  logic            pop;

  assign wr_nxt      = wr_q + PtrW'(1);
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  // two free words guarantee the next byte can always be taken
  assign room_o      = cnt_q <= RoomMax;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.v0) + PtrW'(push_i.v1);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.v0) + CntW'(push_i.v1) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.v1) begin
      mem_q[wr_nxt] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/modbus_tcp_response_parser.sv @@
// Modbus TCP response parser. Takes one frame byte per cycle, with no gaps
// needed, and emits register words, coil bytes and one closing status word per
// frame. Each byte is parsed in the cycle it is accepted and its results land
// in a small result queue (FifoDepth words); the output is read from that
// registered queue, not from the parser; a last byte that completes a data
// word yields the data word and then the status word. Input ready drops only
// while the queue holds more than FifoDepth - 2 words, i.e. when the consumer
// stalls. The expected transaction id register is always writable and must
// only be changed between frames. Words and coil bytes of a frame are sent
// before its status is known; discard them when the status is not success.
`timescale 1ns / 1ps
`include "modbus_tcp_response_parser_defines.svh"

module modbus_tcp_response_parser #(
  parameter int unsigned FifoDepth = mbtcp_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mbtcp_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mbtcp_pkg::res_t  out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [15:0]      cfg_data_i
);

  logic [15:0]      exp_tid_q;
  logic             accept;
  mbtcp_pkg::res_t  res0, res1;
  mbtcp_pkg::push_t push;
  logic             room;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = room;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_tid_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      exp_tid_q <= cfg_data_i;
    end
  end

  mbtcp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .exp_tid_i (exp_tid_q),
    .res0_o    (res0),
    .res1_o    (res1),
    .push_o    (push)
  );

  mbtcp_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `MBTCP_ASSERT(a_second_slot_is_status, push.v1 |-> (push.v0 && res1.is_last && res0.item_kind != mbtcp_pkg::KindStatus), "second result is not a status after data")
  `MBTCP_ASSERT(a_frame_end_gives_output, (accept && in_data_i.frame_end) |=> out_valid_o, "no result after frame end")
  `MBTCP_ASSERT_ALWAYS(a_stall_only_when_full, (!in_ready_o) |-> out_valid_o, "input stalled with empty result queue")

endmodule

@@ tb/sv/tb.sv @@
// testbench for modbus_tcp_response_parser: frames go in a byte at a time and
// every word that comes out is checked against a frame parser kept in the bench
// depends on mbtcp_pkg and the parser rtl only
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseBytes    = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  mbtcp_pkg::in_t    in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  mbtcp_pkg::res_t   out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [15:0]       cfg_data_i;

  modbus_tcp_response_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // bench copy of the parser state
  logic [15:0]                match_tid = '0;
  logic [mbtcp_pkg::PosW-1:0] frame_pos = '0;
  logic [15:0]                seen_tid = '0;
  logic                       header_bad = 1'b0;
  logic [7:0]                 func_code = '0;
  logic [7:0]                 data_count = '0;
  logic [7:0]                 high_byte = '0;

  mbtcp_pkg::res_t expected_results[$];
  mbtcp_pkg::res_t want_res;
  int unsigned     mismatches = 0;
  int unsigned     bytes_accepted = 0;
  int unsigned     stall_cycles = 0;
  bit              sender_idles = 1'b1;
  bit              sink_stalls = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // appends one word to the expected results
  task automatic expect_result(input mbtcp_pkg::res_t r);
    expected_results = {expected_results, r};
  endtask

  // works out what one accepted frame byte produces
  task automatic parse_frame_byte(input logic [7:0] b, input logic fend);
    int unsigned     p;
    int unsigned     idx;
    int unsigned     len;
    mbtcp_pkg::res_t r;
    p = frame_pos;
    if (p == 0) begin
      seen_tid = {b, 8'h00};
    end else if (p == 1) begin
      seen_tid[7:0] = b;
      if (seen_tid != match_tid) header_bad = 1'b1;
    end else if (p == 2 || p == 3) begin
      if (b != 8'h00) header_bad = 1'b1;
    end else if (p == 7) begin
      func_code = b;
    end else if (p == 8) begin
      data_count = b;
    end else if (p >= mbtcp_pkg::HeaderBytes && !header_bad) begin
      idx = p - mbtcp_pkg::HeaderBytes;
      if (idx < data_count) begin
        if (func_code == mbtcp_pkg::FcReadHolding || func_code == mbtcp_pkg::FcReadInput) begin
          if (idx % 2 == 0) begin
            high_byte = b;
          end else begin
            r = '0;
            r.item_kind = mbtcp_pkg::KindWord;
            r.item_value = {high_byte, b};
            expect_result(r);
          end
        end else if (func_code == mbtcp_pkg::FcReadCoils ||
                     func_code == mbtcp_pkg::FcReadDiscrete) begin
          r = '0;
          r.item_kind = mbtcp_pkg::KindCoil;
          r.item_value = {8'h00, b};
          expect_result(r);
        end
      end
    end
    if (frame_pos < mbtcp_pkg::PosMax) frame_pos++;

    if (fend) begin
      len = p + 1;
      r = '0;
      r.item_kind = mbtcp_pkg::KindStatus;
      r.is_last = 1'b1;
      if (len < mbtcp_pkg::HeaderBytes) begin
        r.frame_status = mbtcp_pkg::StatDataErr;
      end else if (header_bad) begin
        r.frame_status = mbtcp_pkg::StatProtoErr;
      end else if (func_code[7]) begin
        r.frame_status = mbtcp_pkg::StatException;
        r.exception_code = data_count;
      end else if (func_code >= mbtcp_pkg::FcReadCoils &&
                   func_code <= mbtcp_pkg::FcReadInput) begin
        r.frame_status = (len < mbtcp_pkg::HeaderBytes + data_count) ?
                         mbtcp_pkg::StatDataErr : mbtcp_pkg::StatOk;
      end else if (func_code == mbtcp_pkg::FcWriteCoil ||
                   func_code == mbtcp_pkg::FcWriteReg ||
                   func_code == mbtcp_pkg::FcWriteCoils ||
                   func_code == mbtcp_pkg::FcWriteRegs) begin
        r.frame_status = mbtcp_pkg::StatOk;
      end else begin
        r.frame_status = mbtcp_pkg::StatProtoErr;
      end
      expect_result(r);
      frame_pos = '0;
      seen_tid = '0;
      header_bad = 1'b0;
      func_code = '0;
      data_count = '0;
      high_byte = '0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic fend);
    int unsigned gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= {b, fend};
    do @(posedge clk_i); while (!in_ready_o);
    parse_frame_byte(b, fend);
    bytes_accepted++;
    @(negedge clk_i);
  endtask

  // header, then data bytes; cut_len > 0 truncates the frame, fill < 0 means random data
  task automatic send_frame(input logic [15:0] tid, input logic [15:0] proto,
                            input logic [7:0] fc, input logic [7:0] cnt,
                            input int n_data, input int cut_len, input int fill);
    logic [7:0] frame_q[$];
    int         n;
    frame_q = {tid[15:8], tid[7:0], proto[15:8], proto[7:0],
               8'($urandom), 8'($urandom), 8'($urandom), fc, cnt};
    repeat (n_data) frame_q = {frame_q, (fill < 0) ? 8'($urandom) : 8'(fill)};
    n = (cut_len > 0 && cut_len < frame_q.size()) ? cut_len : frame_q.size();
    for (int k = 0; k < n; k++) send_byte(frame_q[k], k == n - 1);
  endtask

  // wait until the parser has delivered everything and gone quiet
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_results.size() > 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_match_tid(input logic [15:0] tid);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= tid;
    do @(posedge clk_i); while (!cfg_ready_o);
    match_tid = tid;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_short_frames;
    write_match_tid(16'h0000);
    send_byte(8'hFF, 1'b1);
    send_frame(16'h0000, 16'h0000, mbtcp_pkg::FcReadHolding, 8'd2, 0, 8, -1);
    send_frame(16'h0000, 16'h0000, mbtcp_pkg::FcReadHolding, 8'd0, 0, 0, -1);
  endtask

  task automatic test_register_reads;
    write_match_tid(16'hFFFF);
    send_frame(16'hFFFF, 16'h0000, mbtcp_pkg::FcReadHolding, 8'd4, 4, 0, 8'hFF);
    // odd count, plus bytes past the count
    send_frame(16'hFFFF, 16'h0000, mbtcp_pkg::FcReadInput, 8'd3, 5, 0, 8'h00);
  endtask

  task automatic test_coil_reads;
    send_frame(16'hFFFF, 16'h0000, mbtcp_pkg::FcReadCoils, 8'd2, 2, 0, -1);
    send_frame(16'hFFFF, 16'h0000, mbtcp_pkg::FcReadDiscrete, 8'd1, 3, 0, -1);
  endtask

  task automatic test_write_echoes;
    write_match_tid(16'h1234);
    send_frame(16'h1234, 16'h0000, mbtcp_pkg::FcWriteCoil, 8'h00, 3, 0, -1);
    send_frame(16'h1234, 16'h0000, mbtcp_pkg::FcWriteReg, 8'h00, 3, 0, -1);
    send_frame(16'h1234, 16'h0000, mbtcp_pkg::FcWriteCoils, 8'h00, 3, 0, -1);
    send_frame(16'h1234, 16'h0000, mbtcp_pkg::FcWriteRegs, 8'h00, 3, 0, -1);
  endtask

  task automatic test_exceptions;
    send_frame(16'h1234, 16'h0000, 8'h83, 8'h02, 0, 0, -1);
    send_frame(16'h1234, 16'h0000, 8'hFF, 8'hFF, 2, 0, -1);
  endtask

  task automatic test_header_errors;
    // data after a bad header must not come out
    send_frame(16'h1235, 16'h0000, mbtcp_pkg::FcReadHolding, 8'd2, 2, 0, -1);
    send_frame(16'h1234, 16'h8000, mbtcp_pkg::FcReadCoils, 8'd1, 1, 0, -1);
    send_frame(16'h1234, 16'h0001, mbtcp_pkg::FcReadCoils, 8'd1, 1, 0, -1);
    send_frame(16'h1234, 16'h0000, 8'h00, 8'd0, 0, 0, -1);
    send_frame(16'h1234, 16'h0000, 8'h07, 8'd0, 2, 0, -1);
  endtask

  task automatic test_incomplete_data;
    send_frame(16'h1234, 16'h0000, mbtcp_pkg::FcReadHolding, 8'd6, 3, 0, -1);
    send_frame(16'h1234, 16'h0000, mbtcp_pkg::FcReadCoils, 8'd4, 2, 0, -1);
  endtask

  task automatic test_long_frame;
    // runs the byte position into saturation
    send_frame(16'h1234, 16'h0000, mbtcp_pkg::FcReadCoils, 8'hFF, 504, 0, -1);
  endtask

  task automatic send_random_frame;
    logic [15:0] tid;
    logic [7:0]  fc;
    logic [7:0]  cnt;
    int unsigned pick;
    int          n_data;
    tid = match_tid;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: fc = mbtcp_pkg::FcReadCoils;
        1: fc = mbtcp_pkg::FcReadDiscrete;
        2: fc = mbtcp_pkg::FcReadHolding;
        default: fc = mbtcp_pkg::FcReadInput;
      endcase
      cnt = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 40)) :
                                           8'($urandom_range(0, 12));
      send_frame(tid, 16'h0000, fc, cnt, cnt + $urandom_range(0, 2), 0, -1);
    end else if (pick < 70) begin
      case ($urandom_range(0, 3))
        0: fc = mbtcp_pkg::FcWriteCoil;
        1: fc = mbtcp_pkg::FcWriteReg;
        2: fc = mbtcp_pkg::FcWriteCoils;
        default: fc = mbtcp_pkg::FcWriteRegs;
      endcase
      send_frame(tid, 16'h0000, fc, 8'($urandom), 3, 0, -1);
    end else if (pick < 78) begin
      fc = 8'($urandom) | 8'h80;
      send_frame(tid, 16'h0000, fc, 8'($urandom), $urandom_range(0, 2), 0, -1);
    end else if (pick < 86) begin
      if ($urandom_range(0, 1) == 0) tid = tid ^ 16'($urandom_range(1, 16'hFFFF));
      fc = ($urandom_range(0, 1) == 0) ? mbtcp_pkg::FcReadHolding : mbtcp_pkg::FcReadCoils;
      cnt = 8'($urandom_range(1, 8));
      send_frame(tid, ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'h0000,
                 fc, cnt, cnt, 0, -1);
    end else if (pick < 92) begin
      fc = 8'($urandom_range(mbtcp_pkg::FcReadCoils, mbtcp_pkg::FcReadInput));
      cnt = 8'($urandom_range(0, 10));
      n_data = cnt;
      send_frame(tid, 16'h0000, fc, cnt, n_data, $urandom_range(1, 8 + n_data), -1);
    end else if (pick < 96) begin
      do fc = 8'($urandom_range(0, 127));
      while ((fc >= mbtcp_pkg::FcReadCoils && fc <= mbtcp_pkg::FcWriteReg) ||
             fc == mbtcp_pkg::FcWriteCoils || fc == mbtcp_pkg::FcWriteRegs);
      send_frame(tid, 16'h0000, fc, 8'($urandom), $urandom_range(0, 4), 0, -1);
    end else begin
      // loose bytes with stray frame ends, closed by a final one
      n_data = $urandom_range(1, 12);
      for (int k = 0; k < n_data; k++)
        send_byte(8'($urandom), (k == n_data - 1) || ($urandom_range(0, 5) == 0));
    end
  endtask

  task automatic test_random_traffic;
    int unsigned phase_end;
    logic [15:0] phase_tid;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: phase_tid = 16'hFFFF;
        2: phase_tid = 16'h0000;
        default: phase_tid = 16'($urandom);
      endcase
      write_match_tid(phase_tid);
      if (ph == 3) begin
        sender_idles = 1'b0;
        sink_stalls = 1'b0;
      end
      phase_end = bytes_accepted + PhaseBytes;
      while (bytes_accepted < phase_end) send_random_frame();
    end
  endtask

  // sink side: random stall bursts
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        hold = $urandom_range(1, 6) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d value 0x%0h status %0d",
                 $time, out_data_o.item_kind, out_data_o.item_value,
                 out_data_o.frame_status);
        mismatches++;
      end else begin
        want_res = expected_results.pop_front();
        if (out_data_o.item_kind !== want_res.item_kind)
          report_field("item_kind", want_res.item_kind, out_data_o.item_kind);
        if (out_data_o.item_value !== want_res.item_value)
          report_field("item_value", want_res.item_value, out_data_o.item_value);
        if (out_data_o.frame_status !== want_res.frame_status)
          report_field("frame_status", want_res.frame_status, out_data_o.frame_status);
        if (out_data_o.exception_code !== want_res.exception_code)
          report_field("exception_code", want_res.exception_code,
                       out_data_o.exception_code);
        if (out_data_o.is_last !== want_res.is_last)
          report_field("is_last", want_res.is_last, out_data_o.is_last);
      end
    end
  end

  // counts cycles in which no word moves on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_results.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_short_frames();
    test_register_reads();
    test_coil_reads();
    test_write_echoes();
    test_exceptions();
    test_header_errors();
    test_incomplete_data();
    test_long_frame();
    test_random_traffic();

    drain();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
